### sv/blr_pkg.sv
// blr_pkg: shared types, constants and helpers of the line rasterizer
// no dependencies; imported by every blr module and the top level

package blr_pkg;

  // coordinate width and error-term width (error spans about one and a half deltas)
  localparam int unsigned COORD_BITS = 12;
  localparam int unsigned ERR_BITS   = COORD_BITS + 2;

  typedef logic [COORD_BITS-1:0]      coord_t;
  typedef logic signed [ERR_BITS-1:0] err_t;

  // request codes
  typedef enum logic {
    REQ_LOAD = 1'b0,
    REQ_STEP = 1'b1
  } req_e;

  // input transaction payload
  typedef struct packed {
    req_e   req_type;
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;
  } in_item_t;

  // output transaction payload
  typedef struct packed {
    coord_t pixel_x;
    coord_t pixel_y;
    logic   last_pixel;
  } out_item_t;

  // line parameters worked out on load
  typedef struct packed {
    logic   active;
    logic   steep;
    logic   minor_dir_neg;
    coord_t major_pos;
    coord_t major_end;
    coord_t minor_pos;
    coord_t major_delta;
    coord_t minor_delta;
  } line_setup_t;

  // absolute difference of two coordinates
  function automatic coord_t abs_diff(input coord_t a, input coord_t b);
    coord_t r;
    r = (a > b) ? (a - b) : (b - a);
    return r;
  endfunction

endpackage

### sv/blr_setup.sv
// blr_setup: combinational line setup from two endpoints
// depends on blr_pkg (types and abs_diff)

module blr_setup (
  input  blr_pkg::in_item_t    item_i,
  output blr_pkg::line_setup_t setup_o
);
  import blr_pkg::*;

  logic   steep;
  coord_t ma, mb, mi_a, mi_b;
  coord_t maj_lo, maj_hi, min_lo, min_hi;

  // steepness picks which axis is major; a tie is not steep
  assign steep = abs_diff(item_i.start_y, item_i.end_y) >
                 abs_diff(item_i.start_x, item_i.end_x);

  always_comb begin
    if (steep) begin
      ma   = item_i.start_y;
      mi_a = item_i.start_x;
      mb   = item_i.end_y;
      mi_b = item_i.end_x;
    end else begin
      ma   = item_i.start_x;
      mi_a = item_i.start_y;
      mb   = item_i.end_x;
      mi_b = item_i.end_y;
    end
  end

  // order endpoints so the major coordinate rises
  always_comb begin
    if (ma > mb) begin
      maj_lo = mb;
      maj_hi = ma;
      min_lo = mi_b;
      min_hi = mi_a;
    end else begin
      maj_lo = ma;
      maj_hi = mb;
      min_lo = mi_a;
      min_hi = mi_b;
    end
  end

  // deltas, minor direction and activity
  always_comb begin
    setup_o.steep         = steep;
    setup_o.major_pos     = maj_lo;
    setup_o.major_end     = maj_hi;
    setup_o.minor_pos     = min_lo;
    setup_o.major_delta   = maj_hi - maj_lo;
    setup_o.minor_delta   = abs_diff(min_lo, min_hi);
    setup_o.minor_dir_neg = !(min_lo < min_hi);
    setup_o.active        = (maj_hi != maj_lo);
  end

endmodule

### sv/blr_walker.sv
// blr_walker: line state registers and the per-pixel error step
// depends on blr_pkg (types)

module blr_walker (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_en_i,
  input  blr_pkg::line_setup_t setup_i,
  input  logic                 step_en_i,
  output logic                 active_o,
  output blr_pkg::out_item_t   pixel_o
);
  import blr_pkg::*;

  // one extra bit over the stored error so the doubled sum cannot overflow
  localparam int unsigned WERR_BITS = ERR_BITS + 1;
  typedef logic signed [WERR_BITS-1:0] werr_t;

  logic   active_q, active_d;
  logic   steep_q, steep_d;
  logic   dir_neg_q, dir_neg_d;
  coord_t major_pos_q, major_pos_d;
  coord_t major_end_q, major_end_d;
  coord_t minor_pos_q, minor_pos_d;
  coord_t major_delta_q, major_delta_d;
  coord_t minor_delta_q, minor_delta_d;
  err_t   err_q, err_d;

  coord_t major_next;
  werr_t  err_sum, err_dbl, err_next;
  logic   minor_move;

  // current pixel with the axes swapped back for a steep line
  assign major_next = major_pos_q + coord_t'(1);
  always_comb begin
    if (steep_q) begin
      pixel_o.pixel_x = minor_pos_q;
      pixel_o.pixel_y = major_pos_q;
    end else begin
      pixel_o.pixel_x = major_pos_q;
      pixel_o.pixel_y = minor_pos_q;
    end
    pixel_o.last_pixel = (major_next == major_end_q);
  end
  assign active_o = active_q;

  // error term update
  assign err_sum    = werr_t'(err_q) + werr_t'(minor_delta_q);
  assign err_dbl    = err_sum <<< 1;
  assign minor_move = (err_dbl >= werr_t'(major_delta_q));
  assign err_next   = minor_move ? (err_sum - werr_t'(major_delta_q)) : err_sum;

  // next state: load replaces the line, step advances it
  always_comb begin
    active_d      = active_q;
    steep_d       = steep_q;
    dir_neg_d     = dir_neg_q;
    major_pos_d   = major_pos_q;
    major_end_d   = major_end_q;
    minor_pos_d   = minor_pos_q;
    major_delta_d = major_delta_q;
    minor_delta_d = minor_delta_q;
    err_d         = err_q;
    if (load_en_i) begin
      active_d      = setup_i.active;
      steep_d       = setup_i.steep;
      dir_neg_d     = setup_i.minor_dir_neg;
      major_pos_d   = setup_i.major_pos;
      major_end_d   = setup_i.major_end;
      minor_pos_d   = setup_i.minor_pos;
      major_delta_d = setup_i.major_delta;
      minor_delta_d = setup_i.minor_delta;
      err_d         = '0;
    end else if (step_en_i) begin
      if (minor_move) begin
        minor_pos_d = dir_neg_q ? (minor_pos_q - coord_t'(1)) :
                                  (minor_pos_q + coord_t'(1));
      end
      err_d       = err_t'(err_next);
      major_pos_d = major_next;
      active_d    = (major_next != major_end_q);
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q      <= 1'b0;
      steep_q       <= 1'b0;
      dir_neg_q     <= 1'b0;
      major_pos_q   <= '0;
      major_end_q   <= '0;
      minor_pos_q   <= '0;
      major_delta_q <= '0;
      minor_delta_q <= '0;
      err_q         <= '0;
    end else begin
      active_q      <= active_d;
      steep_q       <= steep_d;
      dir_neg_q     <= dir_neg_d;
      major_pos_q   <= major_pos_d;
      major_end_q   <= major_end_d;
      minor_pos_q   <= minor_pos_d;
      major_delta_q <= major_delta_d;
      minor_delta_q <= minor_delta_d;
      err_q         <= err_d;
    end
  end

endmodule

### sv/bresenham_line_rasterizer.sv
// bresenham_line_rasterizer: one request per cycle unless the output stalls,
// one pixel per step request while a line is active. A request is registered
// at acceptance; a step's pixel then goes into the output register that drives
// out_valid_o, which holds it while out_ready_i is low.
// Reset (rst_ni low, asynchronous) clears both stage valids and all line state.
// depends on blr_pkg, blr_setup, blr_walker

module bresenham_line_rasterizer (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  blr_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output blr_pkg::out_item_t out_item_o
);
  import blr_pkg::*;

  logic        s1_valid_q, s1_valid_d;
  in_item_t    s1_item_q;
  logic        out_valid_q, out_valid_d;
  out_item_t   out_item_q;

  line_setup_t setup;
  out_item_t   pixel;
  logic        active;
  logic        is_step, produces, out_free, s1_fire, out_load;

  // setup logic for a load transaction
  blr_setup u_setup (
    .item_i  (s1_item_q),
    .setup_o (setup)
  );

  // handshake between the input register and the result register
  assign is_step    = (s1_item_q.req_type == REQ_STEP);
  assign produces   = is_step && active;
  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_fire    = s1_valid_q && (!produces || out_free);
  assign out_load   = s1_fire && produces;
  assign in_ready_o = !s1_valid_q || s1_fire;

  // line walker state
  blr_walker u_walker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_en_i (s1_fire && !is_step),
    .setup_i   (setup),
    .step_en_i (out_load),
    .active_o  (active),
    .pixel_o   (pixel)
  );

  // valid bits of both stages
  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_ready_o) begin
      s1_valid_d = in_valid_i;
    end
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_item_q <= in_item_i;
    end
    if (out_load) begin
      out_item_q <= pixel;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

### sv/blr_checker.sv
// blr_checker: port-level assertions for bresenham_line_rasterizer
// depends on blr_pkg; bound to the top level below

module blr_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input blr_pkg::in_item_t  in_item_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input blr_pkg::out_item_t out_item_o
);
  import blr_pkg::*;

  // in reset nothing is offered and input is open
  assert property (@(posedge clk_i) !rst_ni |-> (!out_valid_o && in_ready_o))
    else $error("output valid or input stalled during reset");

  // an empty result register never backs up the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty result register");

  // a draining output always frees the input side
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_o)
    else $error("input stalled while output drains");

  // a stalled result holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_item_o)))
    else $error("stalled result dropped or changed");

endmodule

bind bresenham_line_rasterizer blr_checker u_blr_checker (.*);
